### rtl/core/edc_pkg.sv
// Shared types, codes and constants of the elevator direction controller.
package edc_pkg;

   // Default number of floors served by the car.
   localparam int FLOORS_DEFAULT = 8;

   // Field widths of the request, response and CSR words.
   localparam int REQ_TYPE_W  = 3;
   localparam int CALL_KIND_W = 2;
   localparam int FLOOR_W     = 4;
   localparam int DECISION_W  = 3;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 6;

   // Width used to compare floor numbers against the floor count.
   localparam int FLOOR_CMP_W = 7;

   // Car capacity after reset.
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 6'd10;

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PRESS   = 3'd0,
      REQ_CANCEL  = 3'd1,
      REQ_EVAL    = 3'd2,
      REQ_MOVE    = 3'd3,
      REQ_BOARD   = 3'd4,
      REQ_LEAVE   = 3'd5,
      REQ_SERVICE = 3'd6
   } req_code_type;

   // Call button kinds.
   typedef enum logic [CALL_KIND_W-1:0] {
      KIND_HALL_UP   = 2'd0,
      KIND_HALL_DOWN = 2'd1,
      KIND_CAR       = 2'd2
   } call_kind_type;

   // Evaluation decisions.
   typedef enum logic [DECISION_W-1:0] {
      DEC_NONE   = 3'd0,
      DEC_BUSY   = 3'd1,
      DEC_GROUND = 3'd2,
      DEC_UP     = 3'd3,
      DEC_DOWN   = 3'd4,
      DEC_IDLE   = 3'd5
   } decision_type;

   // Preferred travel direction.
   typedef enum logic [MODE_W-1:0] {
      MODE_NONE = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } mode_type;

   // Motion status of the car.
   typedef enum logic [MODE_W-1:0] {
      STATUS_IDLE = 2'd0,
      STATUS_UP   = 2'd1,
      STATUS_DOWN = 2'd2
   } status_type;

endpackage

### rtl/core/edc_if.sv
// Handshake interfaces for the request, response and CSR channels.
interface edc_req_if;
   logic                             valid;
   logic                             ready;
   logic [edc_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [edc_pkg::CALL_KIND_W-1:0]  call_kind;
   logic [edc_pkg::FLOOR_W-1:0]      call_floor;

   modport source (output valid, req_type, call_kind, call_floor, input ready);
   modport sink   (input valid, req_type, call_kind, call_floor, output ready);
endinterface

interface edc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [edc_pkg::DECISION_W-1:0]   decision;
   logic [edc_pkg::FLOOR_W-1:0]      current_floor;
   logic [edc_pkg::MODE_W-1:0]       travel_mode;
   logic [edc_pkg::MODE_W-1:0]       motion_status;
   logic                             door_due;
   logic                             car_full;
   logic [edc_pkg::COUNT_W-1:0]      passenger_count;
   logic                             refused;

   modport source (output valid, decision, current_floor, travel_mode, motion_status,
                   door_due, car_full, passenger_count, refused, input ready);
   modport sink   (input valid, decision, current_floor, travel_mode, motion_status,
                   door_due, car_full, passenger_count, refused, output ready);
endinterface

interface edc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [edc_pkg::COUNT_W-1:0]      data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/core/elevator_direction_controller.sv
// Top level of the elevator direction controller: call state and one-pass scheduler.
// A request word passes through the input register and then the response register.
// Throughput: one request word per cycle unless the response channel stalls; the
// call-vector OR reductions and scheduler priority settle between the two registers.
// Reset (synchronous, active high) clears all calls, puts the car idle at floor 1 with
// ground wait set and no riders, and loads the capacity register with 10.
module elevator_direction_controller #(
   parameter int FLOORS = edc_pkg::FLOORS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   edc_req_if.sink    req_ch,
   edc_rsp_if.source  rsp_ch,
   edc_csr_if.sink    csr_ch
);
   import edc_pkg::*;

   localparam int FW = $clog2(FLOORS);

   // Input register.
   logic                     in_valid_ff;
   logic [REQ_TYPE_W-1:0]    req_type_ff;
   logic [CALL_KIND_W-1:0]   call_kind_ff;
   logic [FLOOR_W-1:0]       call_floor_ff;

   // Controller state.
   logic [FLOORS-1:0]        up_ff, up_in;
   logic [FLOORS-1:0]        down_ff, down_in;
   logic [FLOORS-1:0]        car_ff, car_in;
   logic [FW-1:0]            floor_ff, floor_in;
   mode_type                 mode_ff, mode_in;
   status_type               status_ff, status_in;
   logic                     ground_ff, ground_in;
   logic [COUNT_W-1:0]       riders_ff, riders_in;
   logic [COUNT_W-1:0]       capacity_ff;

   // Response register.
   logic                     rsp_valid_ff;
   decision_type             decision_ff, decision_in;
   logic [FLOOR_W-1:0]       cur_floor_ff, cur_floor_in;
   logic                     door_ff, door_in;
   logic                     full_ff, full_in;
   logic                     refused_ff, refused_in;

   // Scheduler helpers.
   logic [FLOORS-1:0]        any_calls;
   logic [FLOORS-1:0]        above_mask;
   logic [FLOORS-1:0]        below_mask;
   logic [FLOORS-1:0]        here_mask;
   logic [FLOORS-1:0]        call_bit;
   logic                     calls_above;
   logic                     calls_below;
   logic [FLOOR_CMP_W-1:0]   floor_ext;
   logic                     advance;

   // Handshakes: the input stage moves on when the response register is free or drains.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         req_type_ff   <= req_ch.req_type;
         call_kind_ff  <= req_ch.call_kind;
         call_floor_ff <= req_ch.call_floor;
      end
   end

   // Per-floor masks relative to the car and to the requested floor.
   always_comb begin
      for (int i = 0; i < FLOORS; i++) begin
         above_mask[i] = FW'(i) > floor_ff;
         below_mask[i] = FW'(i) < floor_ff;
         here_mask[i]  = FW'(i) == floor_ff;
         call_bit[i]   = FLOOR_CMP_W'(call_floor_ff) == FLOOR_CMP_W'(i + 1);
      end
   end

   assign any_calls   = up_ff | down_ff | car_ff;
   assign calls_above = |(any_calls & above_mask);
   assign calls_below = |(any_calls & below_mask);

   // Next state and result of the request in the input register.
   always_comb begin
      up_in       = up_ff;
      down_in     = down_ff;
      car_in      = car_ff;
      floor_in    = floor_ff;
      mode_in     = mode_ff;
      status_in   = status_ff;
      ground_in   = ground_ff;
      riders_in   = riders_ff;
      decision_in = DEC_NONE;
      refused_in  = 1'b0;

      unique case (req_type_ff)
         REQ_PRESS: begin
            if (call_kind_ff == KIND_HALL_UP) begin
               up_in = up_ff | call_bit;
            end else if (call_kind_ff == KIND_HALL_DOWN) begin
               down_in = down_ff | call_bit;
            end else if (call_kind_ff == KIND_CAR) begin
               car_in = car_ff | call_bit;
            end
         end
         REQ_CANCEL: begin
            if (call_kind_ff == KIND_HALL_UP) begin
               up_in = up_ff & ~call_bit;
            end else if (call_kind_ff == KIND_HALL_DOWN) begin
               down_in = down_ff & ~call_bit;
            end else if (call_kind_ff == KIND_CAR) begin
               car_in = car_ff & ~call_bit;
            end
         end
         REQ_EVAL: begin
            // Preferred side first (up if none), then the other, then hall calls here.
            priority if (status_ff != STATUS_IDLE) begin
               decision_in = DEC_BUSY;
            end else if (ground_ff && any_calls[0]) begin
               ground_in   = 1'b0;
               decision_in = DEC_GROUND;
            end else if ((mode_ff != MODE_DOWN) && calls_above) begin
               decision_in = DEC_UP;
            end else if (calls_below) begin
               decision_in = DEC_DOWN;
            end else if (calls_above) begin
               decision_in = DEC_UP;
            end else if (up_ff[floor_ff]) begin
               decision_in = DEC_UP;
            end else if (down_ff[floor_ff]) begin
               decision_in = DEC_DOWN;
            end else begin
               decision_in = DEC_IDLE;
               mode_in     = MODE_NONE;
               if (floor_ff == '0) begin
                  ground_in = 1'b1;
               end
            end
            if (decision_in == DEC_UP) begin
               mode_in   = MODE_UP;
               status_in = STATUS_UP;
            end else if (decision_in == DEC_DOWN) begin
               mode_in   = MODE_DOWN;
               status_in = STATUS_DOWN;
            end
         end
         REQ_MOVE: begin
            if (status_ff == STATUS_DOWN && floor_ff != '0) begin
               floor_in = floor_ff - FW'(1);
            end else if (status_ff == STATUS_UP && floor_ff != FW'(FLOORS - 1)) begin
               floor_in = floor_ff + FW'(1);
            end
            status_in = STATUS_IDLE;
            ground_in = 1'b0;
         end
         REQ_BOARD: begin
            if (riders_ff >= capacity_ff) begin
               refused_in = 1'b1;
            end else begin
               riders_in = riders_ff + COUNT_W'(1);
            end
         end
         REQ_LEAVE: begin
            if (riders_ff == '0) begin
               refused_in = 1'b1;
            end else begin
               riders_in = riders_ff - COUNT_W'(1);
            end
         end
         REQ_SERVICE: begin
            if (mode_ff == MODE_UP) begin
               up_in = up_ff & ~here_mask;
            end else if (mode_ff == MODE_DOWN) begin
               down_in = down_ff & ~here_mask;
            end
            car_in    = car_ff & ~here_mask;
            ground_in = 1'b0;
         end
         default: begin
         end
      endcase

      // Status fields follow the updated state.
      door_in = ((mode_in == MODE_UP) && up_in[floor_in]) ||
                ((mode_in == MODE_DOWN) && down_in[floor_in]) ||
                car_in[floor_in];
      full_in      = riders_in >= capacity_ff;
      floor_ext    = FLOOR_CMP_W'(floor_in) + FLOOR_CMP_W'(1);
      cur_floor_in = floor_ext[FLOOR_W-1:0];
   end

   // Controller state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff     <= '0;
         down_ff   <= '0;
         car_ff    <= '0;
         floor_ff  <= '0;
         mode_ff   <= MODE_NONE;
         status_ff <= STATUS_IDLE;
         ground_ff <= 1'b1;
         riders_ff <= '0;
      end else if (advance) begin
         up_ff     <= up_in;
         down_ff   <= down_in;
         car_ff    <= car_in;
         floor_ff  <= floor_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         ground_ff <= ground_in;
         riders_ff <= riders_in;
      end
   end

   // Capacity register written from the CSR channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_ch.valid) begin
         capacity_ff <= csr_ch.data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         decision_ff  <= decision_in;
         cur_floor_ff <= cur_floor_in;
         door_ff      <= door_in;
         full_ff      <= full_in;
         refused_ff   <= refused_in;
      end
   end

   // The mode and status of the response word are taken from the state itself.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.decision        = decision_ff;
   assign rsp_ch.current_floor   = cur_floor_ff;
   assign rsp_ch.travel_mode     = mode_ff;
   assign rsp_ch.motion_status   = status_ff;
   assign rsp_ch.door_due        = door_ff;
   assign rsp_ch.car_full        = full_ff;
   assign rsp_ch.passenger_count = riders_ff;
   assign rsp_ch.refused         = refused_ff;

`ifndef SYNTHESIS
   // A moving car always travels in its preferred direction.
   assert property (@(posedge clock) disable iff (reset)
      (status_ff == STATUS_UP) |-> (mode_ff == MODE_UP))
      else $error("car moving up without up mode");
   assert property (@(posedge clock) disable iff (reset)
      (status_ff == STATUS_DOWN) |-> (mode_ff == MODE_DOWN))
      else $error("car moving down without down mode");
   // The car never leaves the served floors.
   assert property (@(posedge clock) disable iff (reset)
      floor_ff <= FW'(FLOORS - 1))
      else $error("floor index out of range");
   // A move always ends with the car idle.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (req_type_ff == REQ_MOVE)) |=> (status_ff == STATUS_IDLE))
      else $error("car not idle after a move");
   // A refused board or leave implies a full or empty car.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && refused_ff) |-> (full_ff || (riders_ff == '0)))
      else $error("refusal with room and riders");
`endif

endmodule
